/* rtl/slm_pkg.sv */
// ----------------------------------------------------------------------------
// slm_pkg: shared types and constants of the sorted list merger
// Function codes, default list depth and the control/status bundles that
// pass between the merge controller and the list stores.
// ----------------------------------------------------------------------------
package slm_pkg;

  // Width of one list element
  localparam int unsigned DATA_W = 32;

  // Default number of entries per list
  localparam int unsigned LIST_DEPTH_DEFAULT = 128;

  // Function codes carried in s_tuser
  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_PULL   = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  // Commands from the controller to one list store
  typedef struct packed {
    logic load;     // append wr_value behind the last entry
    logic clear;    // drop all entries
    logic advance;  // consume the head entry
  } list_ctrl_t;

  // Status of one list store
  typedef struct packed {
    logic left;      // at least one entry not yet consumed
    logic one_left;  // exactly one entry not yet consumed
  } list_stat_t;

endpackage

/* rtl/slm_list.sv */
// ----------------------------------------------------------------------------
// slm_list: one list store
// Synchronous memory with an append pointer (count) and a read pointer
// (head). The head entry is read every cycle into a registered output.
// ----------------------------------------------------------------------------
module slm_list #(
  parameter int unsigned LIST_DEPTH = slm_pkg::LIST_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  slm_pkg::list_ctrl_t               ctrl,
  input  logic signed [slm_pkg::DATA_W-1:0] wr_value,
  output logic signed [slm_pkg::DATA_W-1:0] rd_data,
  output slm_pkg::list_stat_t               stat
);

  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);

  logic signed [slm_pkg::DATA_W-1:0] mem [LIST_DEPTH];

  logic [CW-1:0] count;
  logic [CW-1:0] head;
  logic          full;

  assign full = (count == CW'(LIST_DEPTH));

  // Memory write at the append pointer, registered read at the head
  always_ff @(posedge clk) begin
    if (ctrl.load && !full) begin
      mem[count[AW-1:0]] <= wr_value;
    end
    rd_data <= mem[head[AW-1:0]];
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      count <= '0;
      head  <= '0;
    end else begin
      if (ctrl.load && !full) begin
        count <= CW'(count + CW'(1));
      end
      if (ctrl.advance) begin
        head <= CW'(head + CW'(1));
      end
    end
  end

  assign stat.left     = (head < count);
  assign stat.one_left = (CW'(head + CW'(1)) == count);

endmodule

/* rtl/sorted_list_merger.sv */
// ----------------------------------------------------------------------------
// sorted_list_merger: two-way merge of two ascending signed lists
// Loads append to list A or B, a pull emits the next merged element, a clear
// empties both lists.
// ----------------------------------------------------------------------------
// Loads and clears produce no output item. A pull is accepted in the idle
// state and moves the controller to the pull state, where the registered
// read of both list heads feeds the head compare, which picks the element;
// the result is written to the output register. If that register
// still holds an item not yet taken, the pull waits until it is. Ties go to
// list A. A pull with both lists used up returns none_left with a zero value.
// Appends to a full list are dropped. No clearing pass is needed after reset.
module sorted_list_merger #(
  parameter int unsigned LIST_DEPTH = slm_pkg::LIST_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input items
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic signed [slm_pkg::DATA_W-1:0] s_tdata,   // [31:0] item_value
  input  logic [1:0]                        s_tuser,   // [1:0] func
  // Output items
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic signed [slm_pkg::DATA_W-1:0] m_tdata,   // [31:0] merged_value
  output logic [1:0]                        m_tuser,   // [0] from_list_b, [1] none_left
  output logic                              m_tlast    // is_last
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PULL = 1'b1;

  logic state;
  logic state_next;

  slm_pkg::list_ctrl_t ctrl_a, ctrl_b;
  slm_pkg::list_stat_t stat_a, stat_b;
  logic signed [slm_pkg::DATA_W-1:0] rd_a, rd_b;

  logic in_fire;
  logic emit;
  logic take_b;
  logic is_last;

  // List stores
  slm_list #(.LIST_DEPTH(LIST_DEPTH)) u_list_a (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl_a),
    .wr_value (s_tdata),
    .rd_data  (rd_a),
    .stat     (stat_a)
  );

  slm_list #(.LIST_DEPTH(LIST_DEPTH)) u_list_b (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl_b),
    .wr_value (s_tdata),
    .rd_data  (rd_b),
    .stat     (stat_b)
  );

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  // Pull completes once the output register is free
  assign emit     = (state == ST_PULL) && (!m_tvalid || m_tready);

  // Head compare: B only when strictly smaller, or when A is used up
  always_comb begin
    if (stat_a.left && stat_b.left) begin
      take_b = (rd_b < rd_a);
    end else begin
      take_b = stat_b.left;
    end
    if (take_b) begin
      is_last = !stat_a.left && stat_b.one_left;
    end else begin
      is_last = !stat_b.left && stat_a.one_left;
    end
  end

  // List commands
  always_comb begin
    ctrl_a.load    = in_fire && (s_tuser == slm_pkg::FUNC_LOAD_A);
    ctrl_b.load    = in_fire && (s_tuser == slm_pkg::FUNC_LOAD_B);
    ctrl_a.clear   = in_fire && (s_tuser == slm_pkg::FUNC_CLEAR);
    ctrl_b.clear   = ctrl_a.clear;
    ctrl_a.advance = emit && stat_a.left && !take_b;
    ctrl_b.advance = emit && take_b;
  end

  // Controller
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && (s_tuser == slm_pkg::FUNC_PULL)) begin
          state_next = ST_PULL;
        end
      end
      ST_PULL: begin
        if (emit) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (!stat_a.left && !stat_b.left) begin
        m_tdata <= '0;
        m_tuser <= 2'b10;
        m_tlast <= 1'b0;
      end else begin
        m_tdata <= take_b ? rd_b : rd_a;
        m_tuser <= {1'b0, take_b};
        m_tlast <= is_last;
      end
    end
  end

`ifndef SYNTH
  // Empty-merge result carries a zero value and is never marked last
  a_none_left_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> (m_tdata == '0) && !m_tlast && !m_tuser[0])
    else $error("none_left item with nonzero payload");

  // An accepted pull blocks further input for the read cycle
  a_pull_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == slm_pkg::FUNC_PULL) |=> !s_tready)
    else $error("input accepted during pull");

  // Taking from B requires B to hold an entry
  a_take_b_valid: assert property (@(posedge clk) disable iff (rst)
    emit && take_b |-> stat_b.left)
    else $error("picked list B while empty");
`endif

endmodule

/* tb/merge_checker.sv */
// ----------------------------------------------------------------------------
// merge_checker: scoreboard for the sorted list merger
// Watches both stream channels, keeps its own copy of both lists and their
// read heads, predicts the merged item for every accepted pull and compares
// each output item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module merge_checker #(
  parameter int unsigned LIST_DEPTH = slm_pkg::LIST_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic signed [slm_pkg::DATA_W-1:0] s_tdata,   // [31:0] item_value
  input  logic [1:0]                        s_tuser,   // [1:0] func
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic signed [slm_pkg::DATA_W-1:0] m_tdata,   // [31:0] merged_value
  input  logic [1:0]                        m_tuser,   // [0] from_list_b, [1] none_left
  input  logic                              m_tlast,   // is_last
  output int                                errors,
  output int                                pending,
  output int                                merged_seen,
  output int                                empty_pulls
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [slm_pkg::DATA_W-1:0] value;
    logic                              from_b;
    logic                              last;
    logic                              none_left;
  } merged_item_t;

  // Shadow copy of the merge state
  logic signed [slm_pkg::DATA_W-1:0] shadow_a [LIST_DEPTH];
  logic signed [slm_pkg::DATA_W-1:0] shadow_b [LIST_DEPTH];
  int unsigned  len_a, len_b, rd_a, rd_b;
  merged_item_t merged_q [$];
  int           mismatch_cnt, seen_cnt, empty_cnt;

  // Update the shadow lists for one accepted input item; a pull queues the
  // merged item it must produce
  task automatic apply_item(input logic [1:0] func,
                            input logic signed [slm_pkg::DATA_W-1:0] value);
    logic         a_left, b_left, take_b;
    merged_item_t nxt;
    case (func)
      slm_pkg::FUNC_LOAD_A: begin
        // appends to a full list are dropped
        if (len_a < LIST_DEPTH) begin
          shadow_a[len_a] = value;
          len_a++;
        end
      end
      slm_pkg::FUNC_LOAD_B: begin
        if (len_b < LIST_DEPTH) begin
          shadow_b[len_b] = value;
          len_b++;
        end
      end
      slm_pkg::FUNC_CLEAR: begin
        len_a = 0;
        len_b = 0;
        rd_a  = 0;
        rd_b  = 0;
      end
      slm_pkg::FUNC_PULL: begin
        a_left = (rd_a < len_a);
        b_left = (rd_b < len_b);
        nxt    = '0;
        if (!a_left && !b_left) begin
          nxt.none_left = 1'b1;
          empty_cnt++;
        end else begin
          // signed head compare, ties stay with list A
          if (a_left && b_left) take_b = !(shadow_a[rd_a] <= shadow_b[rd_b]);
          else take_b = b_left;
          if (take_b) begin
            nxt.value = shadow_b[rd_b];
            rd_b++;
          end else begin
            nxt.value = shadow_a[rd_a];
            rd_a++;
          end
          nxt.from_b = take_b;
          nxt.last   = (rd_a >= len_a) && (rd_b >= len_b);
        end
        merged_q.push_back(nxt);
      end
      default: ;
    endcase
  endtask

  // Output side is checked before the input side: a result leaving at this
  // edge always belongs to a pull accepted earlier
  always @(posedge clk) begin
    merged_item_t want;
    if (rst) begin
      len_a        = 0;
      len_b        = 0;
      rd_a         = 0;
      rd_b         = 0;
      mismatch_cnt = 0;
      seen_cnt     = 0;
      empty_cnt    = 0;
      merged_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen_cnt++;
        if (merged_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: unexpected output item value %0d tuser %b tlast %b",
                     $realtime, m_tdata, m_tuser, m_tlast);
        end else begin
          want = merged_q.pop_front();
          if (m_tdata !== want.value || m_tuser[0] !== want.from_b ||
              m_tuser[1] !== want.none_left || m_tlast !== want.last) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: merged item mismatch", $realtime);
              $display("  expected value %0d from_b %b none_left %b last %b",
                       want.value, want.from_b, want.none_left, want.last);
              $display("  actual   value %0d from_b %b none_left %b last %b",
                       m_tdata, m_tuser[0], m_tuser[1], m_tlast);
            end
          end
        end
      end
      if (s_tvalid && s_tready) apply_item(s_tuser, s_tdata);
    end
    errors      <= mismatch_cnt;
    pending     <= merged_q.size();
    merged_seen <= seen_cnt;
    empty_pulls <= empty_cnt;
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the sorted list merger
// Drives directed corner cases, then random well-formed merges, unsorted
// loads, a full-list fill and noise under changing backpressure; the checker
// beside the block predicts and compares every merged item.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = slm_pkg::LIST_DEPTH_DEFAULT;
  localparam int          RAND_ITEMS  = 560;
  localparam int          HOLD_CYCLES = 300;

  logic                              clk;
  logic                              rst;
  logic                              s_tvalid;
  logic                              s_tready;
  logic signed [slm_pkg::DATA_W-1:0] s_tdata;   // [31:0] item_value
  logic [1:0]                        s_tuser;   // [1:0] func
  logic                              m_tvalid;
  logic                              m_tready;
  logic signed [slm_pkg::DATA_W-1:0] m_tdata;   // [31:0] merged_value
  logic [1:0]                        m_tuser;   // [0] from_list_b, [1] none_left
  logic                              m_tlast;   // is_last

  int errors, pending, merged_seen, empty_pulls;
  int tx_idle_pct, rx_idle_pct;
  int items_sent, fills_done;
  bit hold_req;

  sorted_list_merger #(.LIST_DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  merge_checker #(.LIST_DEPTH(DEPTH)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .errors      (errors),
    .pending     (pending),
    .merged_seen (merged_seen),
    .empty_pulls (empty_pulls)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("** sorted_list_merger: FAILED **");
    $finish;
  end

  // Output side: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one item, with random gaps first, and wait for it to be taken
  task automatic send(input logic [1:0] func, input int value);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= func;
    do @(posedge clk); while (!s_tready);
    if (func != slm_pkg::FUNC_CLEAR) items_sent++;
  endtask

  function automatic int rand_value(input bit narrow);
    // narrow values give plenty of ties between the two lists
    if (narrow) return $urandom_range(6) - 3;
    return $urandom;
  endfunction

  // Clear, load two sorted lists interleaved, then pull them out (sometimes
  // past the end, sometimes with an append in the middle of the merge)
  task automatic merge_run();
    int  vals_a[$], vals_b[$];
    int  n_a, n_b, ia, ib, n_pull;
    bit  narrow;
    narrow = $urandom_range(2) == 0;
    n_a    = $urandom_range(8);
    n_b    = $urandom_range(8);
    for (int i = 0; i < n_a; i++) vals_a.push_back(rand_value(narrow));
    for (int i = 0; i < n_b; i++) vals_b.push_back(rand_value(narrow));
    vals_a.sort();
    vals_b.sort();
    send(slm_pkg::FUNC_CLEAR, $urandom);
    ia = 0;
    ib = 0;
    while (ia < n_a || ib < n_b) begin
      if (ib >= n_b || (ia < n_a && $urandom_range(1))) begin
        send(slm_pkg::FUNC_LOAD_A, vals_a[ia]);
        ia++;
      end else begin
        send(slm_pkg::FUNC_LOAD_B, vals_b[ib]);
        ib++;
      end
    end
    n_pull = n_a + n_b + $urandom_range(2);
    for (int i = 0; i < n_pull; i++) begin
      if (i == n_pull / 2 && $urandom_range(3) == 0)
        send($urandom_range(1) ? slm_pkg::FUNC_LOAD_B : slm_pkg::FUNC_LOAD_A,
             rand_value(narrow));
      send(slm_pkg::FUNC_PULL, $urandom);
    end
  endtask

  // Overfill one list, add a few to the other, then drain everything
  task automatic fill_run(input bit hold);
    int  vals[$];
    bit  to_b;
    to_b = ($urandom_range(1) != 0);
    for (int i = 0; i < DEPTH + 2; i++) vals.push_back($urandom);
    vals.sort();
    send(slm_pkg::FUNC_CLEAR, $urandom);
    foreach (vals[i]) send(to_b ? slm_pkg::FUNC_LOAD_B : slm_pkg::FUNC_LOAD_A, vals[i]);
    for (int i = 0; i < 3; i++)
      send(to_b ? slm_pkg::FUNC_LOAD_A : slm_pkg::FUNC_LOAD_B, $urandom);
    // the receiver stops while pulls keep coming, so the block backs up
    if (hold) hold_req = 1'b1;
    for (int i = 0; i < DEPTH + 4; i++) send(slm_pkg::FUNC_PULL, $urandom);
    fills_done++;
  endtask

  // Loads without order and a partial drain, no clear first
  task automatic unsorted_run();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      send($urandom_range(1) ? slm_pkg::FUNC_LOAD_B : slm_pkg::FUNC_LOAD_A, $urandom);
    n = $urandom_range(n);
    for (int i = 0; i < n; i++) send(slm_pkg::FUNC_PULL, $urandom);
  endtask

  // Stimulus and verdict
  initial begin
    int base, done, pick;
    bit pressure_done;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = slm_pkg::FUNC_CLEAR;
    hold_req    = 1'b0;
    items_sent  = 0;
    fills_done  = 0;
    tx_idle_pct = 38;
    rx_idle_pct = 77;
    pressure_done = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: pull on empty lists
    send(slm_pkg::FUNC_PULL, 0);
    // extremes on both sides, ties at the minimum and maximum
    send(slm_pkg::FUNC_LOAD_A, 32'sh8000_0000);
    send(slm_pkg::FUNC_LOAD_A, -1);
    send(slm_pkg::FUNC_LOAD_A, 32'sh7FFF_FFFF);
    send(slm_pkg::FUNC_LOAD_B, 32'sh8000_0000);
    send(slm_pkg::FUNC_LOAD_B, 0);
    send(slm_pkg::FUNC_LOAD_B, 32'sh7FFF_FFFF);
    repeat (4) send(slm_pkg::FUNC_PULL, 0);
    // append in the middle of the merge, out of order on purpose
    send(slm_pkg::FUNC_LOAD_B, 5);
    repeat (3) send(slm_pkg::FUNC_PULL, 0);
    // everything used up
    send(slm_pkg::FUNC_PULL, 0);
    // clear, a single element is also the last one
    send(slm_pkg::FUNC_CLEAR, 0);
    send(slm_pkg::FUNC_LOAD_A, 7);
    send(slm_pkg::FUNC_PULL, 0);
    // clear drops a pending element
    send(slm_pkg::FUNC_LOAD_B, 3);
    send(slm_pkg::FUNC_CLEAR, -1);
    send(slm_pkg::FUNC_PULL, 0);

    // Random part in three backpressure phases; the last one opens with the
    // full-list fill and its long hold-off
    base = items_sent;
    done = 0;
    while (done < RAND_ITEMS) begin
      if (done >= RAND_ITEMS / 2) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        if (!pressure_done) begin
          pressure_done = 1'b1;
          fill_run(1'b1);
        end
      end else if (done >= RAND_ITEMS / 4) begin
        tx_idle_pct = 77;
        rx_idle_pct = 38;
      end
      pick = $urandom_range(99);
      if (pick < 75) merge_run();
      else if (pick < 90) unsorted_run();
      else begin
        repeat ($urandom_range(1, 5)) send(2'($urandom_range(3)), $urandom);
      end
      done = items_sent - base;
    end
    s_tvalid <= 1'b0;

    // Drain, then a few more cycles for anything stray
    do @(posedge clk); while (pending != 0);
    repeat (10) @(posedge clk);

    $display("Run covered %0d load/pull items, %0d full-list fills, one %0d-cycle hold-off.",
             items_sent, fills_done, HOLD_CYCLES);
    $display("%0d merged items checked, %0d of them empty pulls, %0d mismatches.",
             merged_seen, empty_pulls, errors);
    if (errors == 0 && pending == 0) begin
      $display("** sorted_list_merger: PASSED **");
    end else begin
      $display("** sorted_list_merger: FAILED **");
    end
    $finish;
  end

endmodule
